// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication violated");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication violated");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/fw3_pkg.sv -----
`default_nettype none

package fw3_pkg;

   // Field widths of the request and response beats.
   localparam int COORD_W     = 5;
   localparam int WORD_W      = 32;
   localparam int SUM_W       = 36;
   localparam int NUM_AXES    = 3;
   localparam int NUM_CORNERS = 8;
   localparam int CORNER_W    = 3;

   // Command codes.
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Controller states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_SETUP,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_Q_SETUP,
      ST_Q_READ,
      ST_Q_DRAIN,
      ST_Q_FOLD,
      ST_Q_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_wr;
      logic load_req;
      logic add_start;
      logic add_rd;
      logic add_wr;
      logic corner_load;
      logic q_rd;
      logic step;
      logic fold;
      logic load_out;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic add_skip;
      logic corner_empty;
      logic nest_last;
      logic clear_last;
      logic last_corner;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// ----- sv/fw3_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module fw3_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- sv/fw3_datapath.sv -----
`default_nettype none
`include "assert_macros.svh"

// Tree storage, axis index counters, corner accumulators and response register.
module fw3_datapath #(
   parameter int SIDE = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire fw3_pkg::ctrl_type                   ctrl,
   output fw3_pkg::stat_type                        stat,
   input  wire logic                                req_cmd,
   input  wire logic        [fw3_pkg::COORD_W-1:0]  req_x_low,
   input  wire logic        [fw3_pkg::COORD_W-1:0]  req_y_low,
   input  wire logic        [fw3_pkg::COORD_W-1:0]  req_z_low,
   input  wire logic        [fw3_pkg::COORD_W-1:0]  req_x_high,
   input  wire logic        [fw3_pkg::COORD_W-1:0]  req_y_high,
   input  wire logic        [fw3_pkg::COORD_W-1:0]  req_z_high,
   input  wire logic signed [fw3_pkg::WORD_W-1:0]   req_amount,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic signed      [fw3_pkg::SUM_W-1:0]    rsp_box_sum
);

   localparam int COORD_W  = fw3_pkg::COORD_W;
   localparam int WORD_W   = fw3_pkg::WORD_W;
   localparam int SUM_W    = fw3_pkg::SUM_W;
   localparam int NAX      = fw3_pkg::NUM_AXES;
   localparam int CORNER_W = fw3_pkg::CORNER_W;
   localparam int IW       = $clog2(SIDE);
   localparam int CW       = IW + 1;
   localparam int AW       = NAX * IW;
   localparam int DEPTH    = 1 << AW;

   // Saturate a coordinate to the last grid index.
   function automatic logic [CW-1:0] clamp_coord(input logic [COORD_W-1:0] v);
      logic [31:0] v32;
      v32 = 32'(v);
      if (v32 >= 32'(SIDE)) begin
         v32 = 32'(SIDE - 1);
      end
      return v32[CW-1:0];
   endfunction

   // Latched request.
   logic                cmd_ff, cmd_in;
   logic [COORD_W-1:0]  lo_ff [NAX];
   logic [COORD_W-1:0]  lo_in [NAX];
   logic [COORD_W-1:0]  hi_ff [NAX];
   logic [COORD_W-1:0]  hi_in [NAX];
   logic [WORD_W-1:0]   amount_ff, amount_in;

   // Walk state.
   logic [CORNER_W-1:0] corner_ff, corner_in;
   logic [CW-1:0]       cnt_ff [NAX];
   logic [CW-1:0]       cnt_in [NAX];
   logic [CW-1:0]       start_ff [NAX];
   logic [CW-1:0]       start_in [NAX];
   logic [WORD_W-1:0]   acc_ff, acc_in;
   logic signed [SUM_W-1:0] total_ff, total_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;

   // Combinational helpers.
   logic [CW-1:0]       corner_coord [NAX];
   logic [NAX-1:0]      corner_void;
   logic [CW-1:0]       nxt [NAX];
   logic [NAX-1:0]      ends;
   logic [CW-1:0]       up;
   logic [CW-1:0]       dn;
   logic [NAX-1:0]      lo_out;
   logic [AW-1:0]       cell_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [WORD_W-1:0]   wr_data;
   logic [WORD_W-1:0]   rd_data;
   logic signed [SUM_W-1:0] term;

   // Per-axis corner coordinates, add range check and chain successors.
   always_comb begin
      up = '0;
      dn = '0;
      for (int s = 0; s < NAX; s++) begin
         lo_out[s] = 32'(lo_ff[s]) >= 32'(SIDE);
         if (corner_ff[NAX-1-s]) begin
            corner_coord[s] = clamp_coord(hi_ff[s]);
            corner_void[s]  = 1'b0;
         end else begin
            corner_coord[s] = clamp_coord(lo_ff[s] - COORD_W'(1));
            corner_void[s]  = (lo_ff[s] == '0);
         end
         up = cnt_ff[s] | (cnt_ff[s] + CW'(1));
         dn = cnt_ff[s] & (cnt_ff[s] + CW'(1));
         if (cmd_ff == fw3_pkg::CMD_QUERY) begin
            ends[s] = (dn == '0);
            nxt[s]  = dn - CW'(1);
         end else begin
            ends[s] = 32'(up) >= 32'(SIDE);
            nxt[s]  = up;
         end
      end
   end

   assign cell_addr = {cnt_ff[0][IW-1:0], cnt_ff[1][IW-1:0], cnt_ff[2][IW-1:0]};

   // Status back to the controller.
   always_comb begin
      stat.add_skip     = |lo_out;
      stat.corner_empty = |corner_void;
      stat.nest_last    = &ends;
      stat.clear_last   = &clr_addr_ff;
      stat.last_corner  = (corner_ff == CORNER_W'(fw3_pkg::NUM_CORNERS - 1));
      stat.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   // Request latch, walk counters and accumulators.
   always_comb begin
      cmd_in    = cmd_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      amount_in = amount_ff;
      corner_in = corner_ff;
      cnt_in    = cnt_ff;
      start_in  = start_ff;
      acc_in    = acc_ff;
      total_in  = total_ff;
      term      = SUM_W'(signed'(acc_ff));

      if (ctrl.load_req) begin
         cmd_in    = req_cmd;
         lo_in[0]  = req_x_low;
         lo_in[1]  = req_y_low;
         lo_in[2]  = req_z_low;
         hi_in[0]  = req_x_high;
         hi_in[1]  = req_y_high;
         hi_in[2]  = req_z_high;
         amount_in = req_amount;
         corner_in = '0;
         total_in  = '0;
      end

      // Chain starts: the point for an add, the corner for a query.
      if (ctrl.add_start) begin
         for (int s = 0; s < NAX; s++) begin
            start_in[s] = clamp_coord(lo_ff[s]);
            cnt_in[s]   = clamp_coord(lo_ff[s]);
         end
      end
      if (ctrl.corner_load) begin
         start_in = corner_coord;
         cnt_in   = corner_coord;
         acc_in   = '0;
      end

      // Nested walk: z is innermost, x outermost.
      if (ctrl.step) begin
         if (!ends[2]) begin
            cnt_in[2] = nxt[2];
         end else begin
            cnt_in[2] = start_ff[2];
            if (!ends[1]) begin
               cnt_in[1] = nxt[1];
            end else begin
               cnt_in[1] = start_ff[1];
               if (!ends[0]) begin
                  cnt_in[0] = nxt[0];
               end
            end
         end
      end

      // Corner prefix sum wraps at the word width.
      if (rd_pend_ff) begin
         acc_in = acc_ff + rd_data;
      end

      // Plus when an even number of axes use the lower corner.
      if (ctrl.fold) begin
         if (^corner_ff) begin
            total_in = total_ff + term;
         end else begin
            total_in = total_ff - term;
         end
         corner_in = corner_ff + CORNER_W'(1);
      end
   end

   // Control registers: clear sweep, read tracking, response valid.
   always_comb begin
      rd_pend_in  = ctrl.q_rd;
      clr_addr_in = ctrl.clear_wr ? clr_addr_ff + AW'(1) : clr_addr_ff;
      rsp_sum_in  = ctrl.load_out ? total_ff : rsp_sum_ff;
      if (ctrl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff   <= rd_pend_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      amount_ff  <= amount_in;
      corner_ff  <= corner_in;
      cnt_ff     <= cnt_in;
      start_ff   <= start_in;
      acc_ff     <= acc_in;
      total_ff   <= total_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   // Tree store port muxing: clear sweep or read-modify-write of an add.
   assign wr_en   = ctrl.clear_wr | ctrl.add_wr;
   assign wr_addr = ctrl.clear_wr ? clr_addr_ff : cell_addr;
   assign wr_data = ctrl.clear_wr ? '0 : rd_data + amount_ff;

   fw3_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_tree (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctrl.add_rd | ctrl.q_rd),
      .rd_addr (cell_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_box_sum = rsp_sum_ff;

   // The add write goes to the cell read in the cycle before.
   `ASSERT_IMPLIES(a_rmw_addr, clock, reset, ctrl.add_wr, $past(ctrl.add_rd) && $stable(cell_addr))
   // Every read of a corner is in the accumulator before it is folded.
   `ASSERT_IMPLIES(a_fold_drained, clock, reset, ctrl.fold, !rd_pend_ff)
   // A response only appears through a load from the controller.
   `ASSERT_IMPLIES(a_rsp_load, clock, reset, $rose(rsp_valid_ff), $past(ctrl.load_out))

endmodule

`default_nettype wire

// ----- sv/fw3_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"

// Sequencer for the clear sweep, point adds and box queries.
module fw3_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_cmd,
   output logic                   req_ready,
   input  wire fw3_pkg::stat_type stat,
   output fw3_pkg::ctrl_type      ctrl
);

   fw3_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fw3_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         fw3_pkg::ST_CLEAR: begin
            ctrl.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = fw3_pkg::ST_IDLE;
            end
         end
         fw3_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load_req = 1'b1;
               if (req_cmd == fw3_pkg::CMD_QUERY) begin
                  state_in = fw3_pkg::ST_Q_SETUP;
               end else begin
                  state_in = fw3_pkg::ST_ADD_SETUP;
               end
            end
         end
         fw3_pkg::ST_ADD_SETUP: begin
            ctrl.add_start = 1'b1;
            state_in = stat.add_skip ? fw3_pkg::ST_IDLE : fw3_pkg::ST_ADD_RD;
         end
         fw3_pkg::ST_ADD_RD: begin
            ctrl.add_rd = 1'b1;
            state_in    = fw3_pkg::ST_ADD_WR;
         end
         fw3_pkg::ST_ADD_WR: begin
            ctrl.add_wr = 1'b1;
            ctrl.step   = 1'b1;
            state_in = stat.nest_last ? fw3_pkg::ST_IDLE : fw3_pkg::ST_ADD_RD;
         end
         fw3_pkg::ST_Q_SETUP: begin
            ctrl.corner_load = 1'b1;
            state_in = stat.corner_empty ? fw3_pkg::ST_Q_FOLD : fw3_pkg::ST_Q_READ;
         end
         fw3_pkg::ST_Q_READ: begin
            ctrl.q_rd = 1'b1;
            ctrl.step = 1'b1;
            if (stat.nest_last) begin
               state_in = fw3_pkg::ST_Q_DRAIN;
            end
         end
         fw3_pkg::ST_Q_DRAIN: begin
            // The last cell of the corner lands in the accumulator here.
            state_in = fw3_pkg::ST_Q_FOLD;
         end
         fw3_pkg::ST_Q_FOLD: begin
            ctrl.fold = 1'b1;
            state_in = stat.last_corner ? fw3_pkg::ST_Q_DONE : fw3_pkg::ST_Q_SETUP;
         end
         fw3_pkg::ST_Q_DONE: begin
            if (stat.rsp_free) begin
               ctrl.load_out = 1'b1;
               state_in      = fw3_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fw3_pkg::ST_IDLE;
         end
      endcase
   end

   // An add write always follows the read of the same cell.
   `ASSERT_IMPLIES(a_wr_after_rd, clock, reset, state_ff == fw3_pkg::ST_ADD_WR, $past(state_ff) == fw3_pkg::ST_ADD_RD)
   // A finished sum waits while the response register is still taken.
   `ASSERT_NEXT(a_done_holds, clock, reset, (state_ff == fw3_pkg::ST_Q_DONE) && !stat.rsp_free, state_ff == fw3_pkg::ST_Q_DONE)

endmodule

`default_nettype wire

// ----- sv/fenwick_3d_point_add_box_sum.sv -----
// Three-dimensional Fenwick tree over a SIDE x SIDE x SIDE grid of 32-bit
// counters. An add beat (cmd 0) adds amount at (x_low, y_low, z_low) and
// gives no response; a coordinate of SIDE or more leaves the tree unchanged.
// A query beat (cmd 1) returns the 36-bit signed sum over the inclusive box,
// built from eight corner prefix sums; coordinates beyond the grid saturate.
// One item is worked at a time, limited by the single read port of the tree
// memory. An add passes a setup state, then a read and a write for each
// ancestor cell, the product of the chain lengths on the three axes: at most
// 6^3 cells for SIDE = 32. A query, for each of the eight corners, passes a
// setup state, one read per cell of the three prefix chains (at most 5^3
// for SIDE = 32), a drain state and a fold state; a corner below zero skips
// the reads and the drain. A done state then waits for the response register.
// A new item is taken while an earlier response still waits. After reset
// the tree is cleared, one word a cycle, over all 2^(3 * ceil(log2(SIDE)))
// words (32768 for SIDE = 32); no item is accepted until it completes.
`default_nettype none

module fenwick_3d_point_add_box_sum #(
   parameter int SIDE = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_cmd,
   input  wire logic        [fw3_pkg::COORD_W-1:0] req_x_low,
   input  wire logic        [fw3_pkg::COORD_W-1:0] req_y_low,
   input  wire logic        [fw3_pkg::COORD_W-1:0] req_z_low,
   input  wire logic        [fw3_pkg::COORD_W-1:0] req_x_high,
   input  wire logic        [fw3_pkg::COORD_W-1:0] req_y_high,
   input  wire logic        [fw3_pkg::COORD_W-1:0] req_z_high,
   input  wire logic signed [fw3_pkg::WORD_W-1:0]  req_amount,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed      [fw3_pkg::SUM_W-1:0]   rsp_box_sum
);

   fw3_pkg::ctrl_type ctrl;
   fw3_pkg::stat_type stat;

   fw3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   fw3_datapath #(
      .SIDE (SIDE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .stat        (stat),
      .req_cmd     (req_cmd),
      .req_x_low   (req_x_low),
      .req_y_low   (req_y_low),
      .req_z_low   (req_z_low),
      .req_x_high  (req_x_high),
      .req_y_high  (req_y_high),
      .req_z_high  (req_z_high),
      .req_amount  (req_amount),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_box_sum (rsp_box_sum)
   );

endmodule

`default_nettype wire

// ----- test/fenwick_3d_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the 3D Fenwick tree block, keeps its own copy of
// the tree, and compares every response beat with the oldest predicted sum.
module fenwick_3d_checker #(
   parameter int SIDE = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   input  wire logic                                  req_ready,
   input  wire logic                                  req_cmd,
   input  wire logic        [fw3_pkg::COORD_W-1:0]    req_x_low,
   input  wire logic        [fw3_pkg::COORD_W-1:0]    req_y_low,
   input  wire logic        [fw3_pkg::COORD_W-1:0]    req_z_low,
   input  wire logic        [fw3_pkg::COORD_W-1:0]    req_x_high,
   input  wire logic        [fw3_pkg::COORD_W-1:0]    req_y_high,
   input  wire logic        [fw3_pkg::COORD_W-1:0]    req_z_high,
   input  wire logic signed [fw3_pkg::WORD_W-1:0]     req_amount,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   input  wire logic signed [fw3_pkg::SUM_W-1:0]      rsp_box_sum,
   output int                                         mismatches,
   output int                                         pending
);

   localparam int WORD_W      = fw3_pkg::WORD_W;
   localparam int SUM_W       = fw3_pkg::SUM_W;
   localparam int CORNER_W    = fw3_pkg::CORNER_W;
   localparam int NUM_CORNERS = fw3_pkg::NUM_CORNERS;
   localparam int CELLS       = SIDE * SIDE * SIDE;

   // Shadow copy of the tree words and the sums still owed by the block.
   logic [WORD_W-1:0]        shadow_tree [CELLS];
   logic signed [SUM_W-1:0]  owed_sums [$];

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   function automatic int cell_at(int x, int y, int z);
      return (x * SIDE + y) * SIDE + z;
   endfunction

   // A point add touches every ancestor along x, y and z.
   function automatic void tree_point_add(int x, int y, int z, logic [WORD_W-1:0] amt);
      int i;
      int j;
      int k;
      for (i = x; i < SIDE; i = i | (i + 1))
         for (j = y; j < SIDE; j = j | (j + 1))
            for (k = z; k < SIDE; k = k | (k + 1))
               shadow_tree[cell_at(i, j, k)] += amt;
   endfunction

   // Inclusive prefix sum from the origin; corners past the grid saturate and
   // a corner below zero gives an empty sum.
   function automatic logic signed [WORD_W-1:0] prefix_sum(int x, int y, int z);
      logic [WORD_W-1:0] acc;
      int i;
      int j;
      int k;
      acc = '0;
      if (x >= SIDE) x = SIDE - 1;
      if (y >= SIDE) y = SIDE - 1;
      if (z >= SIDE) z = SIDE - 1;
      for (i = x; i >= 0; i = (i & (i + 1)) - 1)
         for (j = y; j >= 0; j = (j & (j + 1)) - 1)
            for (k = z; k >= 0; k = (k & (k + 1)) - 1)
               acc += shadow_tree[cell_at(i, j, k)];
      return acc;
   endfunction

   // Inclusion-exclusion over the eight corners. Each corner sum wraps at the
   // word width, then the signed terms are added exactly.
   function automatic logic signed [SUM_W-1:0] box_sum_of(int xl, int yl, int zl,
                                                          int xh, int yh, int zh);
      longint                total;
      longint                term;
      logic [CORNER_W-1:0]   corner;
      int                    cx;
      int                    cy;
      int                    cz;
      total = 0;
      for (int m = 0; m < NUM_CORNERS; m++) begin
         corner = m[CORNER_W-1:0];
         cx = corner[2] ? xh : xl - 1;
         cy = corner[1] ? yh : yl - 1;
         cz = corner[0] ? zh : zl - 1;
         term = prefix_sum(cx, cy, cz);
         if (^corner)
            total += term;
         else
            total -= term;
      end
      return total[SUM_W-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // Responses are retired before requests are taken, so a response in the
   // same cycle as a new query always belongs to an earlier one.
   always @(posedge clock) begin
      logic signed [SUM_W-1:0] want;
      if (reset) begin
         foreach (shadow_tree[n]) shadow_tree[n] = '0;
         owed_sums.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_sums.size() == 0) begin
               report_mismatch($sformatf("response beat %0d with no query waiting",
                                         rsp_box_sum));
            end else begin
               want = owed_sums.pop_front();
               if (rsp_box_sum !== want)
                  report_mismatch($sformatf("box_sum got %0d expected %0d",
                                            rsp_box_sum, want));
            end
         end
         if (req_valid && req_ready) begin
            if (req_cmd == fw3_pkg::CMD_QUERY)
               owed_sums.push_back(box_sum_of(int'(req_x_low), int'(req_y_low),
                                              int'(req_z_low), int'(req_x_high),
                                              int'(req_y_high), int'(req_z_high)));
            else
               tree_point_add(int'(req_x_low), int'(req_y_low), int'(req_z_low),
                              req_amount);
         end
      end
      pending = owed_sums.size();
   end

endmodule

// ----- test/tb_fenwick_3d_point_add_box_sum.sv -----
`timescale 1ns / 1ps

// Drives add and query beats into the 3D Fenwick tree block with bursty
// traffic and a stalling receiver; the checker beside the block predicts and
// compares every response.
module tb_fenwick_3d_point_add_box_sum;

   localparam int COORD_W        = fw3_pkg::COORD_W;
   localparam int WORD_W         = fw3_pkg::WORD_W;
   localparam int SUM_W          = fw3_pkg::SUM_W;
   localparam int SIDE           = 32;
   localparam int RANDOM_BEATS   = 600;
   localparam int HOLD_CYCLES    = 4000;
   localparam int SETTLE_CYCLES  = 600;
   localparam int WATCHDOG_LIMIT = 100000;
   localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(SIDE - 1);

   typedef struct {
      logic                       cmd;
      logic [COORD_W-1:0]         x_low;
      logic [COORD_W-1:0]         y_low;
      logic [COORD_W-1:0]         z_low;
      logic [COORD_W-1:0]         x_high;
      logic [COORD_W-1:0]         y_high;
      logic [COORD_W-1:0]         z_high;
      logic signed [WORD_W-1:0]   amount;
   } fenwick_beat_type;

   typedef enum int {
      DRAIN_ALWAYS,
      DRAIN_COIN,
      DRAIN_SPARSE
   } drain_mode_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_cmd;
   logic [COORD_W-1:0]         req_x_low;
   logic [COORD_W-1:0]         req_y_low;
   logic [COORD_W-1:0]         req_z_low;
   logic [COORD_W-1:0]         req_x_high;
   logic [COORD_W-1:0]         req_y_high;
   logic [COORD_W-1:0]         req_z_high;
   logic signed [WORD_W-1:0]   req_amount;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SUM_W-1:0]    rsp_box_sum;
   int                         mismatches;
   int                         pending;
   bit                         hold_drain;

   fenwick_3d_point_add_box_sum #(
      .SIDE(SIDE)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .req_x_low  (req_x_low),
      .req_y_low  (req_y_low),
      .req_z_low  (req_z_low),
      .req_x_high (req_x_high),
      .req_y_high (req_y_high),
      .req_z_high (req_z_high),
      .req_amount (req_amount),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_box_sum(rsp_box_sum)
   );

   fenwick_3d_checker #(
      .SIDE(SIDE)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .req_x_low  (req_x_low),
      .req_y_low  (req_y_low),
      .req_z_low  (req_z_low),
      .req_x_high (req_x_high),
      .req_y_high (req_y_high),
      .req_z_high (req_z_high),
      .req_amount (req_amount),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_box_sum(rsp_box_sum),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Coordinates lean toward the grid edges.
   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return COORD_MAX;
         default: return COORD_W'($urandom_range(0, SIDE - 1));
      endcase
   endfunction

   // Amounts mix the signed extremes, small values and full-width noise.
   function automatic logic signed [WORD_W-1:0] pick_amount();
      case ($urandom_range(0, 9))
         0:       return {1'b0, {(WORD_W - 1){1'b1}}};
         1:       return {1'b1, {(WORD_W - 1){1'b0}}};
         2:       return '1;
         3:       return WORD_W'(int'($urandom_range(0, 200)) - 100);
         default: return $urandom;
      endcase
   endfunction

   // The unused fields of each beat carry random values.
   function automatic fenwick_beat_type make_add(logic [COORD_W-1:0] x,
                                                 logic [COORD_W-1:0] y,
                                                 logic [COORD_W-1:0] z,
                                                 logic signed [WORD_W-1:0] amt);
      fenwick_beat_type b;
      b.cmd    = fw3_pkg::CMD_ADD;
      b.x_low  = x;
      b.y_low  = y;
      b.z_low  = z;
      b.x_high = COORD_W'($urandom);
      b.y_high = COORD_W'($urandom);
      b.z_high = COORD_W'($urandom);
      b.amount = amt;
      return b;
   endfunction

   function automatic fenwick_beat_type make_query(logic [COORD_W-1:0] xl,
                                                   logic [COORD_W-1:0] yl,
                                                   logic [COORD_W-1:0] zl,
                                                   logic [COORD_W-1:0] xh,
                                                   logic [COORD_W-1:0] yh,
                                                   logic [COORD_W-1:0] zh);
      fenwick_beat_type b;
      b.cmd    = fw3_pkg::CMD_QUERY;
      b.x_low  = xl;
      b.y_low  = yl;
      b.z_low  = zl;
      b.x_high = xh;
      b.y_high = yh;
      b.z_high = zh;
      b.amount = $urandom;
      return b;
   endfunction

   function automatic fenwick_beat_type random_beat();
      if ($urandom_range(0, 1) == 0)
         return make_add(pick_coord(), pick_coord(), pick_coord(), pick_amount());
      return make_query(pick_coord(), pick_coord(), pick_coord(),
                        pick_coord(), pick_coord(), pick_coord());
   endfunction

   // Every call happens at a falling edge, so each input gets one update there.
   task automatic drive_beat(input fenwick_beat_type b, input logic valid);
      req_valid  <= valid;
      req_cmd    <= b.cmd;
      req_x_low  <= b.x_low;
      req_y_low  <= b.y_low;
      req_z_low  <= b.z_low;
      req_x_high <= b.x_high;
      req_y_high <= b.y_high;
      req_z_high <= b.z_high;
      req_amount <= b.amount;
   endtask

   // Offer one beat and hold it until the block takes it.
   task automatic send_beat(input fenwick_beat_type b);
      drive_beat(b, 1'b1);
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         drive_beat(random_beat(), 1'b0);
         @(negedge clock);
      end
   endtask

   // Stop offering until every owed response has come back.
   task automatic wait_drained();
      idle_sender(1);
      while (pending != 0) @(negedge clock);
   endtask

   function automatic int pick_gap();
      case ($urandom_range(0, 9))
         0, 1, 2: return 0;
         3:       return $urandom_range(20, 60);
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   // Receiver: ready follows a pattern picked at random for a random span,
   // with one long hold-off on request from the stimulus.
   initial begin
      drain_mode_type mode;
      int             span;
      bit             held;
      mode      = DRAIN_ALWAYS;
      span      = 0;
      held      = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_drain && !held) begin
            held = 1'b1;
            repeat (HOLD_CYCLES) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end
         if (span == 0) begin
            mode = drain_mode_type'($urandom_range(0, 2));
            span = $urandom_range(1, 150);
         end
         span--;
         case (mode)
            DRAIN_ALWAYS: rsp_ready <= 1'b1;
            DRAIN_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            default:      rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Watchdog: too long without any beat on either channel ends the run.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      fenwick_beat_type directed_beats[$];
      int               sent;
      int               burst;
      bit               paused_mid;

      reset      = 1'b1;
      hold_drain = 1'b0;
      req_valid  = 1'b0;
      req_cmd    = fw3_pkg::CMD_ADD;
      req_x_low  = '0;
      req_y_low  = '0;
      req_z_low  = '0;
      req_x_high = '0;
      req_y_high = '0;
      req_z_high = '0;
      req_amount = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed beats: empty tree, signed extremes, a lower-corner sum of
      // the most negative word being negated, a wrapping corner sum, lower
      // corners at zero, grid edges and inverted boxes.
      directed_beats.push_back(make_query('0, '0, '0, COORD_MAX, COORD_MAX, COORD_MAX));
      directed_beats.push_back(make_add(5'd1, 5'd1, 5'd1, {1'b1, {(WORD_W - 1){1'b0}}}));
      directed_beats.push_back(make_query(5'd2, 5'd2, 5'd2, 5'd5, 5'd5, 5'd5));
      directed_beats.push_back(make_query('0, '0, '0, COORD_MAX, COORD_MAX, COORD_MAX));
      directed_beats.push_back(make_add('0, '0, '0, {1'b0, {(WORD_W - 1){1'b1}}}));
      directed_beats.push_back(make_add('0, '0, '0, {1'b0, {(WORD_W - 1){1'b1}}}));
      directed_beats.push_back(make_query('0, '0, '0, '0, '0, '0));
      directed_beats.push_back(make_query(5'd1, 5'd1, 5'd1, COORD_MAX, COORD_MAX, COORD_MAX));
      directed_beats.push_back(make_add(COORD_MAX, COORD_MAX, COORD_MAX, '1));
      directed_beats.push_back(make_add(COORD_MAX, '0, 5'd16, 32'sd1));
      directed_beats.push_back(make_add(5'd5, 5'd17, 5'd9, 32'sd12345));
      directed_beats.push_back(make_query(COORD_MAX, COORD_MAX, COORD_MAX,
                                          COORD_MAX, COORD_MAX, COORD_MAX));
      directed_beats.push_back(make_query(5'd20, 5'd20, 5'd20, 5'd3, 5'd3, 5'd3));
      directed_beats.push_back(make_query(COORD_MAX, '0, '0, '0, COORD_MAX, COORD_MAX));
      directed_beats.push_back(make_query('0, 5'd17, '0, COORD_MAX, 5'd17, COORD_MAX));
      directed_beats.push_back(make_add(5'd30, 5'd30, 5'd30, {1'b0, {(WORD_W - 1){1'b1}}}));
      directed_beats.push_back(make_query(5'd30, 5'd30, 5'd30, COORD_MAX, COORD_MAX,
                                          COORD_MAX));
      directed_beats.push_back(make_query('0, '0, '0, 5'd30, 5'd30, 5'd30));
      directed_beats.push_back(make_add(5'd16, 5'd16, 5'd16, {1'b1, {(WORD_W - 1){1'b0}}}));
      directed_beats.push_back(make_query(5'd16, '0, '0, 5'd16, COORD_MAX, COORD_MAX));
      directed_beats.push_back(make_query('0, '0, '0, COORD_MAX, COORD_MAX, COORD_MAX));
      foreach (directed_beats[n]) begin
         send_beat(directed_beats[n]);
         idle_sender($urandom_range(0, 3));
      end
      wait_drained();

      // Long receiver hold-off while queries keep coming, so the block fills
      // and stalls its input.
      hold_drain = 1'b1;
      repeat (8)
         send_beat(make_query(pick_coord(), pick_coord(), pick_coord(),
                              pick_coord(), pick_coord(), pick_coord()));
      wait_drained();

      // Random traffic in bursts, with one full drain half way through.
      sent       = 0;
      paused_mid = 1'b0;
      while (sent < RANDOM_BEATS) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            send_beat(random_beat());
            sent++;
         end
         if (!paused_mid && sent >= RANDOM_BEATS / 2) begin
            wait_drained();
            paused_mid = 1'b1;
         end
         idle_sender(pick_gap());
      end

      // Let the last responses and any trailing add finish.
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- fenwick_3d_point_add_box_sum.f -----
+incdir+sv
sv/fw3_pkg.sv
sv/fw3_ram.sv
sv/fw3_datapath.sv
sv/fw3_ctrl.sv
sv/fenwick_3d_point_add_box_sum.sv
test/fenwick_3d_checker.sv
test/tb_fenwick_3d_point_add_box_sum.sv
